// ===== rtl/phga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package phga_pkg;

  // Sizing
  localparam int NUM_PARAMS        = 64;
  localparam int MAX_EVENT_INDICES = 16;
  localparam int HESS_DEPTH        = NUM_PARAMS * (NUM_PARAMS + 1) / 2;

  // Field widths fixed by the interface
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;

  // Derived widths
  localparam int PAR_W   = $clog2(NUM_PARAMS);
  localparam int HESS_AW = $clog2(HESS_DEPTH);
  localparam int CNT_W   = $clog2(MAX_EVENT_INDICES + 1);
  localparam int LIST_AW = (MAX_EVENT_INDICES > 1) ? $clog2(MAX_EVENT_INDICES) : 1;
  localparam int POS_W   = 2 * PAR_W + 1;

  typedef enum logic [1:0] {
    CMD_INDEX = 2'd0,
    CMD_HESS  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROP    = 2'd1,
    ST_SURPLUS = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  // Store access request for one beat, built in the sequencer stage
  typedef struct packed {
    logic                 rmw_h;
    logic                 rmw_g;
    logic                 rd_h;
    logic                 rd_g;
    status_t              status;
    logic [HESS_AW-1:0]   h_addr;
    logic [PAR_W-1:0]     g_addr;
  } req_t;

  // Packed row-major position of (min, max) in the upper triangle
  function automatic logic [HESS_AW-1:0] packed_pos(input logic [PAR_W-1:0] a,
                                                    input logic [PAR_W-1:0] b);
    logic [PAR_W-1:0] i;
    logic [PAR_W-1:0] j;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] tri_n;
    logic [POS_W-1:0] pos;
    i = (a < b) ? a : b;
    j = (a < b) ? b : a;
    base = POS_W'(i) * POS_W'(NUM_PARAMS);
    if (i == '0) begin
      tri_n = '0;
    end else begin
      tri_n = (POS_W'(i) * POS_W'(i - 1'b1)) >> 1;
    end
    pos = base - tri_n + POS_W'(j - i);
    return pos[HESS_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/phga_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phga_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0]   wa,
  input  wire logic [W-1:0]                           wd,
  input  wire logic                                   re,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0]   ra,
  output logic      [W-1:0]                           rd
);

  logic [W-1:0] mem [D];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/phga_sat_add.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phga_sat_add (
  input  wire logic signed [phga_pkg::SUM_W-1:0] acc,
  input  wire logic signed [phga_pkg::VAL_W-1:0] val,
  output logic signed      [phga_pkg::SUM_W-1:0] sum,
  output logic                                   sat
);

  logic signed [phga_pkg::SUM_W:0] ext;

  // One guard bit; clamp when the two top bits disagree
  always_comb begin
    ext = (phga_pkg::SUM_W + 1)'(acc) + (phga_pkg::SUM_W + 1)'(val);
    sat = ext[phga_pkg::SUM_W] != ext[phga_pkg::SUM_W-1];
    if (!sat) begin
      sum = ext[phga_pkg::SUM_W-1:0];
    end else if (ext[phga_pkg::SUM_W]) begin
      sum = {1'b1, {(phga_pkg::SUM_W - 1){1'b0}}};
    end else begin
      sum = {1'b0, {(phga_pkg::SUM_W - 1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/phga_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module phga_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire phga_pkg::cmd_t              cmd,
  input  wire logic                        first,
  input  wire logic [phga_pkg::IDX_W-1:0]  p,
  input  wire logic [phga_pkg::IDX_W-1:0]  q,
  output phga_pkg::req_t                   req
);

  localparam int CNT_W   = phga_pkg::CNT_W;
  localparam int LIST_AW = phga_pkg::LIST_AW;
  localparam int PAR_W   = phga_pkg::PAR_W;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [PAR_W-1:0] row_par_r, row_par_nxt;
  logic [PAR_W-1:0] list_r [phga_pkg::MAX_EVENT_INDICES];

  logic [CNT_W-1:0] eff_cnt, eff_row, row_n, col_n;
  logic             p_ok, q_ok, append, adv, pair_ok;
  logic [PAR_W-1:0] p_par, q_par, a_par, b_par, ha, hb;

  // Decode, index-list bookkeeping and pair walk
  always_comb begin
    p_par   = PAR_W'(p);
    q_par   = PAR_W'(q);
    p_ok    = 32'(p) < 32'(phga_pkg::NUM_PARAMS);
    q_ok    = 32'(q) < 32'(phga_pkg::NUM_PARAMS);
    eff_cnt = (cmd == phga_pkg::CMD_INDEX && first) ? '0 : cnt_r;
    eff_row = (cmd == phga_pkg::CMD_INDEX && first) ? '0 : row_r;
    append  = (cmd == phga_pkg::CMD_INDEX) && p_ok &&
              (32'(eff_cnt) < 32'(phga_pkg::MAX_EVENT_INDICES));

    // Row finished: step to the diagonal of the next row
    adv     = (col_r >= cnt_r) && (row_r < cnt_r);
    row_n   = adv ? row_r + 1'b1 : row_r;
    col_n   = adv ? row_r + 1'b1 : col_r;
    pair_ok = (row_n < cnt_r) && (col_n < cnt_r);
    b_par   = list_r[col_n[LIST_AW-1:0]];
    a_par   = adv ? b_par : row_par_r;

    ha = (cmd == phga_pkg::CMD_READ) ? p_par : a_par;
    hb = (cmd == phga_pkg::CMD_READ) ? q_par : b_par;

    req        = '0;
    req.h_addr = phga_pkg::packed_pos(ha, hb);
    req.g_addr = p_par;
    req.status = phga_pkg::ST_OK;

    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    row_par_nxt = row_par_r;

    case (cmd)
      phga_pkg::CMD_INDEX: begin
        cnt_nxt = eff_cnt;
        row_nxt = eff_row;
        if (first) begin
          col_nxt = '0;
        end
        if (append) begin
          req.rmw_g = 1'b1;
          cnt_nxt   = eff_cnt + 1'b1;
          // Entry under the current row: keep the row's parameter at hand
          if (eff_cnt == eff_row) begin
            row_par_nxt = p_par;
          end
        end else begin
          req.status = phga_pkg::ST_DROP;
        end
      end
      phga_pkg::CMD_HESS: begin
        if (adv) begin
          row_nxt     = row_n;
          row_par_nxt = b_par;
        end
        if (pair_ok) begin
          req.rmw_h = 1'b1;
          col_nxt   = col_n + 1'b1;
        end else begin
          req.status = phga_pkg::ST_SURPLUS;
          col_nxt    = col_n;
        end
      end
      phga_pkg::CMD_READ: begin
        req.rd_g = p_ok;
        req.rd_h = p_ok && q_ok;
      end
      default: begin
      end
    endcase
  end

  // Counters and positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      row_r <= '0;
      col_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Index list and cached row parameter
  always_ff @(posedge clk) begin
    if (fire) begin
      row_par_r <= row_par_nxt;
      if (append) begin
        list_r[eff_cnt[LIST_AW-1:0]] <= p_par;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/packed_hessian_gradient_accumulator.sv =====
// A beat passes the input register, the stage 1 register and the output register in order.
// Throughput: one beat per cycle if not stalled; store RMW with a one-deep write forward.
// Reset: synchronous, active low. After reset a clearing pass zeroes both stores,
// one entry per cycle through addresses 0 to HESS_DEPTH-1 (2079), with in_stall held high.
// The event index list holds no reset value; count and pair positions reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module packed_hessian_gradient_accumulator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_command,
  input  wire logic                               in_first_of_event,
  input  wire logic [phga_pkg::IDX_W-1:0]         in_param_index,
  input  wire logic [phga_pkg::IDX_W-1:0]         in_second_index,
  input  wire logic signed [phga_pkg::VAL_W-1:0]  in_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_status,
  output logic signed [phga_pkg::SUM_W-1:0]       out_hessian_sum,
  output logic signed [phga_pkg::SUM_W-1:0]       out_gradient_sum
);

  localparam int SUM_W   = phga_pkg::SUM_W;
  localparam int HESS_AW = phga_pkg::HESS_AW;
  localparam int PAR_W   = phga_pkg::PAR_W;

  // Control
  logic               clr_busy_r, clr_busy_nxt;
  logic [HESS_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               p0_v_r, p0_v_nxt;
  logic               p1_v_r, p1_v_nxt;
  logic               out_v_r, out_v_nxt;
  logic               in_fire, out_adv, p1_free, p1_adv, p0_adv;

  // Payload
  phga_pkg::cmd_t                p0_cmd_r;
  logic                          p0_first_r;
  logic [phga_pkg::IDX_W-1:0]    p0_p_r, p0_q_r;
  logic signed [phga_pkg::VAL_W-1:0] p0_val_r, p1_val_r;
  phga_pkg::req_t                req, p1_req_r;
  logic                          fwd_h_r, fwd_g_r;
  logic signed [SUM_W-1:0]       fwd_hd_r, fwd_gd_r;
  phga_pkg::status_t             out_status_r, status_c;
  logic signed [SUM_W-1:0]       out_h_r, out_g_r;

  // Store ports
  logic                          h_we_user, g_we_user, h_we, g_we;
  logic [HESS_AW-1:0]            h_wa;
  logic [PAR_W-1:0]              g_wa;
  logic signed [SUM_W-1:0]       h_wd, g_wd, h_rd, g_rd, h_old, g_old, h_sum, g_sum;
  logic                          h_sat, g_sat;

  // Handshake and stage advance
  always_comb begin
    out_adv  = !out_v_r || !out_stall;
    p1_free  = !p1_v_r || out_adv;
    p1_adv   = p1_v_r && out_adv;
    p0_adv   = p0_v_r && p1_free;
    in_stall = clr_busy_r || (p0_v_r && !p1_free);
    in_fire  = in_valid && !in_stall;

    p0_v_nxt  = in_fire ? 1'b1 : (p0_adv ? 1'b0 : p0_v_r);
    p1_v_nxt  = p0_adv ? 1'b1 : (p1_adv ? 1'b0 : p1_v_r);
    out_v_nxt = p1_adv ? 1'b1 : (out_adv ? 1'b0 : out_v_r);

    clr_cnt_nxt  = clr_cnt_r + 1'b1;
    clr_busy_nxt = clr_busy_r && (clr_cnt_r != HESS_AW'(phga_pkg::HESS_DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      p0_v_r     <= 1'b0;
      p1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      p0_v_r  <= p0_v_nxt;
      p1_v_r  <= p1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p0_cmd_r   <= phga_pkg::cmd_t'(in_command);
      p0_first_r <= in_first_of_event;
      p0_p_r     <= in_param_index;
      p0_q_r     <= in_second_index;
      p0_val_r   <= in_value;
    end
  end

  // Index list and pair sequencer
  phga_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (p0_adv),
    .cmd   (p0_cmd_r),
    .first (p0_first_r),
    .p     (p0_p_r),
    .q     (p0_q_r),
    .req   (req)
  );

  // Stores: clearing pass owns the write ports after reset
  always_comb begin
    h_we_user = p1_adv && p1_req_r.rmw_h;
    g_we_user = p1_adv && p1_req_r.rmw_g;
    h_we = clr_busy_r || h_we_user;
    g_we = clr_busy_r || g_we_user;
    h_wa = clr_busy_r ? clr_cnt_r : p1_req_r.h_addr;
    g_wa = clr_busy_r ? clr_cnt_r[PAR_W-1:0] : p1_req_r.g_addr;
    h_wd = clr_busy_r ? '0 : h_sum;
    g_wd = clr_busy_r ? '0 : g_sum;
  end

  phga_ram #(.W(SUM_W), .D(phga_pkg::HESS_DEPTH)) u_hess_ram (
    .clk (clk),
    .we  (h_we),
    .wa  (h_wa),
    .wd  (h_wd),
    .re  (p0_adv),
    .ra  (req.h_addr),
    .rd  (h_rd)
  );

  phga_ram #(.W(SUM_W), .D(phga_pkg::NUM_PARAMS)) u_grad_ram (
    .clk (clk),
    .we  (g_we),
    .wa  (g_wa),
    .wd  (g_wd),
    .re  (p0_adv),
    .ra  (req.g_addr),
    .rd  (g_rd)
  );

  // Stage 1 register, with forward of the write landing on the same edge
  always_ff @(posedge clk) begin
    if (p0_adv) begin
      p1_req_r <= req;
      p1_val_r <= p0_val_r;
      fwd_h_r  <= h_we_user && (p1_req_r.h_addr == req.h_addr) && (req.rmw_h || req.rd_h);
      fwd_g_r  <= g_we_user && (p1_req_r.g_addr == req.g_addr) && (req.rmw_g || req.rd_g);
      fwd_hd_r <= h_sum;
      fwd_gd_r <= g_sum;
    end
  end

  // Accumulate
  always_comb begin
    h_old = fwd_h_r ? fwd_hd_r : h_rd;
    g_old = fwd_g_r ? fwd_gd_r : g_rd;
  end

  phga_sat_add u_hess_add (
    .acc (h_old),
    .val (p1_val_r),
    .sum (h_sum),
    .sat (h_sat)
  );

  phga_sat_add u_grad_add (
    .acc (g_old),
    .val (p1_val_r),
    .sum (g_sum),
    .sat (g_sat)
  );

  always_comb begin
    status_c = p1_req_r.status;
    if ((p1_req_r.rmw_h && h_sat) || (p1_req_r.rmw_g && g_sat)) begin
      status_c = phga_pkg::ST_SAT;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_status_r <= status_c;
      out_h_r      <= p1_req_r.rd_h ? h_old : '0;
      out_g_r      <= p1_req_r.rd_g ? g_old : '0;
    end
  end

  assign out_valid        = out_v_r;
  assign out_status       = out_status_r;
  assign out_hessian_sum  = out_h_r;
  assign out_gradient_sum = out_g_r;

  // Checks
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall)
    else $error("beat accepted during store clear");

  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!p0_v_r && !p1_v_r && !out_v_r))
    else $error("pipeline busy during store clear");

  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && fwd_h_r) |-> (p1_req_r.rmw_h || p1_req_r.rd_h))
    else $error("hessian forward on a beat that does not use it");

  a_wr_after_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (h_we_user || g_we_user) |-> !clr_busy_r)
    else $error("accumulate write during store clear");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int IDX_W = phga_pkg::IDX_W;
  localparam int VAL_W = phga_pkg::VAL_W;
  localparam int SUM_W = phga_pkg::SUM_W;
  localparam int NUM_PARAMS = phga_pkg::NUM_PARAMS;
  localparam int MAX_EVENT_INDICES = phga_pkg::MAX_EVENT_INDICES;
  localparam int HESS_DEPTH = phga_pkg::HESS_DEPTH;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam longint SUM_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_BOTTOM = -SUM_TOP - 1;
  localparam int NUM_ROWS = 13;

  typedef struct {
    phga_pkg::status_t status;
    logic signed [SUM_W-1:0] hess;
    logic signed [SUM_W-1:0] grad;
  } acc_result_t;

  typedef struct {
    phga_pkg::cmd_t cmd;
    bit first;
    bit [IDX_W-1:0] p;
    bit [IDX_W-1:0] q;
    bit [VAL_W-1:0] v;
    int reps;
    bit pinned;
    phga_pkg::status_t st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = phga_pkg::CMD_NOP;
  logic in_first_of_event = 1'b0;
  logic [IDX_W-1:0] in_param_index = '0;
  logic [IDX_W-1:0] in_second_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [SUM_W-1:0] out_hessian_sum;
  logic signed [SUM_W-1:0] out_gradient_sum;

  // Predicted accumulator state; 2-state types start at zero like the stores
  longint hess_acc [HESS_DEPTH];
  longint grad_acc [NUM_PARAMS];
  int evt_list [MAX_EVENT_INDICES];
  int evt_count = 0;
  int pair_row = 0;
  int pair_col = 0;

  acc_result_t expected_q [$];
  stim_row_t directed_rows [NUM_ROWS];

  // Beat tag: directed rows may carry a hand-written expectation
  bit beat_pinned = 1'b0;
  phga_pkg::status_t beat_pinned_status = phga_pkg::ST_OK;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  packed_hessian_gradient_accumulator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_first_of_event(in_first_of_event),
    .in_param_index(in_param_index),
    .in_second_index(in_second_index),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_hessian_sum(out_hessian_sum),
    .out_gradient_sum(out_gradient_sum)
  );

  always #10 clk = ~clk;

  // Upper-triangle slot of (min, max), row-major
  function automatic int tri_slot(input int a, input int b);
    int i;
    int j;
    i = (a < b) ? a : b;
    j = (a < b) ? b : a;
    return i * NUM_PARAMS - (i * (i - 1)) / 2 + (j - i);
  endfunction

  function automatic longint clamped_sum(input longint acc, input longint v, output bit hit);
    longint s;
    s = acc + v;
    hit = 1'b0;
    if (s > SUM_TOP) begin
      s = SUM_TOP;
      hit = 1'b1;
    end else if (s < SUM_BOTTOM) begin
      s = SUM_BOTTOM;
      hit = 1'b1;
    end
    return s;
  endfunction

  // Advance the predicted state by one beat and return its result
  function automatic acc_result_t accumulate_beat(input phga_pkg::cmd_t op, input bit first,
                                                  input bit [IDX_W-1:0] p,
                                                  input bit [IDX_W-1:0] q,
                                                  input logic signed [VAL_W-1:0] v);
    acc_result_t res;
    bit hit;
    int slot;
    res.status = phga_pkg::ST_OK;
    res.hess = '0;
    res.grad = '0;
    case (op)
      phga_pkg::CMD_INDEX: begin
        if (first) begin
          evt_count = 0;
          pair_row = 0;
          pair_col = 0;
        end
        if (evt_count >= MAX_EVENT_INDICES || p >= NUM_PARAMS) begin
          res.status = phga_pkg::ST_DROP;
        end else begin
          evt_list[evt_count] = int'(p);
          evt_count++;
          grad_acc[p] = clamped_sum(grad_acc[p], longint'(v), hit);
          if (hit) res.status = phga_pkg::ST_SAT;
        end
      end
      phga_pkg::CMD_HESS: begin
        // end of a row: step to the diagonal of the next one
        if (pair_col >= evt_count && pair_row < evt_count) begin
          pair_row++;
          pair_col = pair_row;
        end
        if (pair_row < evt_count && pair_col < evt_count) begin
          slot = tri_slot(evt_list[pair_row], evt_list[pair_col]);
          hess_acc[slot] = clamped_sum(hess_acc[slot], longint'(v), hit);
          if (hit) res.status = phga_pkg::ST_SAT;
          pair_col++;
        end else begin
          res.status = phga_pkg::ST_SURPLUS;
        end
      end
      phga_pkg::CMD_READ: begin
        if (p < NUM_PARAMS) begin
          res.grad = SUM_W'(grad_acc[p]);
          if (q < NUM_PARAMS) res.hess = SUM_W'(hess_acc[tri_slot(int'(p), int'(q))]);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Prediction on input beats, checking on output beats
  always @(posedge clk) begin : monitor
    acc_result_t r;
    if (rst_n && in_valid && !in_stall) begin
      r = accumulate_beat(phga_pkg::cmd_t'(in_command), in_first_of_event, in_param_index,
                          in_second_index, in_value);
      if (beat_pinned) begin
        r.status = beat_pinned_status;
        r.hess = '0;
        r.grad = '0;
      end
      expected_q = {expected_q, r};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, got status %0d", $time,
                 out_status);
        mismatch_count++;
      end else begin
        r = expected_q.pop_front();
        if (out_status !== r.status) begin
          flag_mismatch("status", longint'(r.status), longint'(out_status));
        end
        if (out_hessian_sum !== r.hess) begin
          flag_mismatch("hessian_sum", longint'(r.hess), longint'(out_hessian_sum));
        end
        if (out_gradient_sum !== r.grad) begin
          flag_mismatch("gradient_sum", longint'(r.grad), longint'(out_gradient_sum));
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("packed_hessian_gradient_accumulator regression: fail");
      $finish;
    end
  end

  // Present one beat from a falling edge and return at the falling edge after acceptance
  task automatic drive_beat(input phga_pkg::cmd_t op, input bit first,
                            input bit [IDX_W-1:0] p, input bit [IDX_W-1:0] q,
                            input bit [VAL_W-1:0] v,
                            input bit pinned, input phga_pkg::status_t st);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= op;
    in_first_of_event <= first;
    in_param_index <= p;
    in_second_index <= q;
    in_value <= v;
    beat_pinned = pinned;
    beat_pinned_status = st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic bit [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  // One event: index beats, its hessian values, then reads; sometimes a noise burst
  task automatic play_event();
    int n;
    int kept;
    int pairs;
    int hess_n;
    int late_at;
    bit [IDX_W-1:0] picks [MAX_EVENT_INDICES];
    bit [IDX_W-1:0] p;
    bit [IDX_W-1:0] rp;
    bit [IDX_W-1:0] rq;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        drive_beat(phga_pkg::cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   IDX_W'($urandom), IDX_W'($urandom), rand_value(), 1'b0,
                   phga_pkg::ST_OK);
      end
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_EVENT_INDICES + 1)
                                    : $urandom_range(1, 5);
    kept = (n > MAX_EVENT_INDICES) ? MAX_EVENT_INDICES : n;
    for (int k = 0; k < n; k++) begin
      p = IDX_W'($urandom);
      if (k < MAX_EVENT_INDICES) picks[k] = p;
      drive_beat(phga_pkg::CMD_INDEX, k == 0, p, IDX_W'($urandom), rand_value(), 1'b0,
                 phga_pkg::ST_OK);
    end
    pairs = kept * (kept + 1) / 2;
    case ($urandom_range(0, 3))
      0: hess_n = pairs + $urandom_range(1, 2);
      1: hess_n = $urandom_range(0, pairs);
      default: hess_n = pairs;
    endcase
    late_at = -1;
    if (kept < MAX_EVENT_INDICES && $urandom_range(0, 5) == 0) begin
      late_at = int'($urandom_range(0, hess_n));
    end
    for (int k = 0; k < hess_n; k++) begin
      if (k == late_at) begin
        drive_beat(phga_pkg::CMD_INDEX, 1'b0, IDX_W'($urandom), IDX_W'($urandom),
                   rand_value(), 1'b0, phga_pkg::ST_OK);
      end
      drive_beat(phga_pkg::CMD_HESS, 1'($urandom_range(0, 1)), IDX_W'($urandom),
                 IDX_W'($urandom), rand_value(), 1'b0, phga_pkg::ST_OK);
    end
    repeat ($urandom_range(0, 3)) begin
      rp = picks[$urandom_range(0, kept - 1)];
      rq = picks[$urandom_range(0, kept - 1)];
      if ($urandom_range(0, 3) == 0) rp = IDX_W'($urandom);
      if ($urandom_range(0, 3) == 0) rq = IDX_W'($urandom);
      drive_beat(phga_pkg::CMD_READ, 1'($urandom_range(0, 1)), rp, rq, $urandom, 1'b0,
                 phga_pkg::ST_OK);
    end
  endtask

  initial begin
    //                  cmd                 first p      q      value          reps pin
    //                  status
    directed_rows[0]  = '{phga_pkg::CMD_READ,  1'b0, 6'd63, 6'd0,  32'h0000_0000, 1,  1'b1,
                          phga_pkg::ST_OK};
    directed_rows[1]  = '{phga_pkg::CMD_HESS,  1'b1, 6'd0,  6'd0,  32'h7FFF_FFFF, 1,  1'b1,
                          phga_pkg::ST_SURPLUS};
    directed_rows[2]  = '{phga_pkg::CMD_NOP,   1'b1, 6'd63, 6'd63, 32'hFFFF_FFFF, 1,  1'b1,
                          phga_pkg::ST_OK};
    directed_rows[3]  = '{phga_pkg::CMD_INDEX, 1'b1, 6'd48, 6'd0,  32'h8000_0000, 16, 1'b1,
                          phga_pkg::ST_OK};
    directed_rows[4]  = '{phga_pkg::CMD_INDEX, 1'b0, 6'd0,  6'd0,  32'h7FFF_FFFF, 1,  1'b1,
                          phga_pkg::ST_DROP};
    directed_rows[5]  = '{phga_pkg::CMD_HESS,  1'b0, 6'd0,  6'd0,  32'h7FFF_FFFF, 2,  1'b0,
                          phga_pkg::ST_OK};
    directed_rows[6]  = '{phga_pkg::CMD_INDEX, 1'b1, 6'd0,  6'd0,  32'h7FFF_FFFF, 1,  1'b1,
                          phga_pkg::ST_OK};
    directed_rows[7]  = '{phga_pkg::CMD_HESS,  1'b0, 6'd0,  6'd0,  32'h8000_0000, 1,  1'b0,
                          phga_pkg::ST_OK};
    directed_rows[8]  = '{phga_pkg::CMD_INDEX, 1'b0, 6'd63, 6'd0,  32'h0001_0000, 1,  1'b1,
                          phga_pkg::ST_OK};
    directed_rows[9]  = '{phga_pkg::CMD_HESS,  1'b0, 6'd0,  6'd0,  32'hFFFF_FFFF, 3,  1'b0,
                          phga_pkg::ST_OK};
    directed_rows[10] = '{phga_pkg::CMD_READ,  1'b0, 6'd63, 6'd0,  32'h0000_0000, 1,  1'b0,
                          phga_pkg::ST_OK};
    directed_rows[11] = '{phga_pkg::CMD_READ,  1'b0, 6'd0,  6'd63, 32'h0000_0000, 1,  1'b0,
                          phga_pkg::ST_OK};
    directed_rows[12] = '{phga_pkg::CMD_READ,  1'b0, 6'd48, 6'd49, 32'h0000_0000, 1,  1'b0,
                          phga_pkg::ST_OK};

    // Reset once; the block then clears its stores with in_stall held
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sender idles lightly, receiver heavily
    send_idle_pct = 14;
    recv_stall_pct = 48;
    for (int r = 0; r < NUM_ROWS; r++) begin
      // repeated rows send their beats one after another; the repeated index row starts one event and fills it
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        drive_beat(directed_rows[r].cmd, directed_rows[r].first && (k == 0),
                   IDX_W'(directed_rows[r].p + k), directed_rows[r].q, directed_rows[r].v,
                   directed_rows[r].pinned, directed_rows[r].st);
      end
    end
    while (beats_sent < 480) play_event();

    // Roles swapped
    send_idle_pct = 48;
    recv_stall_pct = 14;
    while (beats_sent < 950) play_event();

    // Full rate
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (beats_sent < 1400) play_event();

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("packed_hessian_gradient_accumulator regression: pass");
    end else begin
      $display("packed_hessian_gradient_accumulator regression: fail");
    end
    $finish;
  end

endmodule
